>>> src/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types and constants for the timed linear ramp block.
// ----------------------------------------------------------------------------
package tlr_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 16;
    localparam int RATE_W    = 24;
    // divide: |target| << FRAC_BITS over duration
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    // product bits kept: enough for a 16-bit step after the fraction shift
    localparam int ACC_W     = DATA_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int QX_W      = NUM_W + RATE_W;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] target;
        logic [DATA_W-1:0]        duration_ms;
        logic [DATA_W-1:0]        now;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] step;
        logic                     running;
        logic                     error;
    } t_out_rsp;

    typedef enum logic {
        OP_DIV = 1'b0,
        OP_MUL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

>>> src/tlr_unit.sv
// ----------------------------------------------------------------------------
// tlr_unit
// Shared serial arithmetic unit: one adder runs either a restoring divide
// (one quotient bit per cycle) or a shift-add multiply (one bit per cycle).
// ----------------------------------------------------------------------------
module tlr_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tlr_pkg::t_unit_cmd                i_cmd,
    input  logic [tlr_pkg::NUM_W-1:0]         i_dividend,
    input  logic [tlr_pkg::DATA_W-1:0]        i_divisor,
    input  logic [tlr_pkg::DATA_W-1:0]        i_mplier,
    input  logic signed [tlr_pkg::RATE_W-1:0] i_mcand,
    output tlr_pkg::t_unit_sts                o_sts,
    output logic [tlr_pkg::NUM_W-1:0]         o_quot,
    output logic [tlr_pkg::ACC_W-1:0]         o_prod
);
    import tlr_pkg::*;

    logic             r_busy;
    logic             r_done;
    t_op              r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [DATA_W:0]  r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_mcand;
    logic [DATA_W-1:0] r_mpl;

    logic [DATA_W:0]  rem_sh;
    logic [ACC_W-1:0] add_a;
    logic [ACC_W-1:0] add_b;
    logic             add_cin;
    logic [ACC_W:0]   add_sum;
    logic             fits;

    always_comb begin
        rem_sh = {r_rem[DATA_W-1:0], r_quo[NUM_W-1]};
        unique case (r_op)
            OP_DIV: begin
                add_a   = ACC_W'(rem_sh);
                add_b   = ~ACC_W'(i_divisor);
                add_cin = 1'b1;
            end
            OP_MUL: begin
                add_a   = r_acc;
                add_b   = r_mpl[0] ? r_mcand : '0;
                add_cin = 1'b0;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b} + (ACC_W+1)'(add_cin);
        // carry out of a - b means no borrow
        fits    = add_sum[ACC_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_cnt  <= (i_cmd.op == OP_DIV) ? CNT_W'(NUM_W) : CNT_W'(DATA_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem   <= '0;
            r_quo   <= i_dividend;
            r_acc   <= '0;
            r_mcand <= ACC_W'(i_mcand);
            r_mpl   <= i_mplier;
        end else if (r_busy) begin
            if (r_op == OP_DIV) begin
                r_rem <= fits ? add_sum[DATA_W:0] : rem_sh;
                r_quo <= {r_quo[NUM_W-2:0], fits};
            end else begin
                r_acc   <= add_sum[ACC_W-1:0];
                r_mcand <= {r_mcand[ACC_W-2:0], 1'b0};
                r_mpl   <= {1'b0, r_mpl[DATA_W-1:1]};
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quo;
    assign o_prod     = r_acc;

endmodule

>>> src/timed_linear_ramp.sv
// ----------------------------------------------------------------------------
// timed_linear_ramp
// Timed linear ramp generator: start requests arm a ramp and compute its
// fixed-point rate, tick requests return the step due since the last update.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------
//  in      | input     | i_in_valid / o_in_ready | t_in_req
//  out     | output    | o_out_valid/ i_out_ready| t_out_rsp
//
// One request at a time. A start runs NUM_W serial divide steps in the
// shared unit before the response shows; a tick that needs a step runs 16
// serial multiply steps. Rejected starts, idle ticks and final ticks
// respond on the next cycle. A stalled response holds the block until
// taken. Synchronous active-low reset clears the ramp state and returns
// to idle.
// ----------------------------------------------------------------------------
module timed_linear_ramp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tlr_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tlr_pkg::t_out_rsp o_out_rsp
);
    import tlr_pkg::*;

    localparam logic [QX_W-1:0] POS_LIM = QX_W'(RATE_MAX);
    localparam logic [QX_W-1:0] NEG_LIM = QX_W'(RATE_MAX) + QX_W'(1);

    t_state r_state, n_state;
    logic                     r_active;
    logic [DATA_W-1:0]        r_goal;
    logic [DATA_W-1:0]        r_pos;
    logic [DATA_W-1:0]        r_span;
    logic [DATA_W-1:0]        r_begin;
    logic [DATA_W-1:0]        r_last;
    logic signed [RATE_W-1:0] r_rate;
    t_in_req                  r_req;
    t_out_rsp                 r_rsp;

    logic              accept;
    logic              dur_zero;
    logic              ended;
    logic              go_div;
    logic              go_mul;
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] tgt_abs;
    logic [DATA_W-1:0] dt;

    t_unit_cmd         unit_cmd;
    t_unit_sts         unit_sts;
    logic [NUM_W-1:0]  unit_quot;
    logic [ACC_W-1:0]  unit_prod;
    logic [QX_W-1:0]   qx;
    logic signed [RATE_W-1:0] sat_rate;
    logic [DATA_W-1:0] mstep;

    // request decode
    always_comb begin
        accept   = i_in_valid && o_in_ready;
        dur_zero = (i_in_req.duration_ms == '0);
        elapsed  = i_in_req.now - r_begin;
        ended    = (elapsed >= r_span);
        dt       = i_in_req.now - r_last;
        tgt_abs  = i_in_req.target[DATA_W-1] ? (~i_in_req.target + DATA_W'(1))
                                             : i_in_req.target;
        go_div   = accept && (i_in_req.func == FUNC_START) && !dur_zero;
        go_mul   = accept && (i_in_req.func == FUNC_TICK) && r_active && !ended;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (go_div) begin
                    n_state = ST_DIV;
                end else if (go_mul) begin
                    n_state = ST_MUL;
                end else if (accept) begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV, ST_MUL: begin
                if (unit_sts.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_out_valid    = (r_state == ST_OUT);
        unit_cmd.start = go_div || go_mul;
        unit_cmd.op    = go_mul ? OP_MUL : OP_DIV;
    end

    tlr_unit u_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (unit_cmd),
        .i_dividend (NUM_W'(tgt_abs) << FRAC_BITS),
        .i_divisor  (r_req.duration_ms),
        .i_mplier   (dt),
        .i_mcand    (r_rate),
        .o_sts      (unit_sts),
        .o_quot     (unit_quot),
        .o_prod     (unit_prod)
    );

    // sign and clamp the quotient magnitude
    always_comb begin
        qx = QX_W'(unit_quot);
        if (r_req.target[DATA_W-1]) begin
            sat_rate = (qx > NEG_LIM) ? RATE_MIN : RATE_W'(QX_W'(0) - qx);
        end else begin
            sat_rate = (qx > POS_LIM) ? RATE_MAX : RATE_W'(qx);
        end
        mstep = unit_prod[FRAC_BITS +: DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 1'b0;
            r_goal   <= '0;
            r_pos    <= '0;
            r_span   <= '0;
            r_begin  <= '0;
            r_last   <= '0;
            r_rate   <= '0;
        end else begin
            r_state <= n_state;
            if (go_div) begin
                r_active <= 1'b1;
                r_goal   <= r_active ? (r_goal - r_pos + i_in_req.target)
                                     : i_in_req.target;
                r_pos    <= '0;
                r_span   <= i_in_req.duration_ms;
                r_begin  <= i_in_req.now;
                r_last   <= i_in_req.now;
            end else if (accept && (i_in_req.func == FUNC_TICK) && r_active && ended) begin
                r_active <= 1'b0;
            end
            if ((r_state == ST_DIV) && unit_sts.done) begin
                r_rate <= sat_rate;
            end
            if ((r_state == ST_MUL) && unit_sts.done && (mstep != '0)) begin
                r_pos  <= r_pos + mstep;
                r_last <= r_req.now;
            end
        end
    end

    // request copy and response register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_req;
            if (i_in_req.func == FUNC_START) begin
                r_rsp.step    <= '0;
                r_rsp.running <= r_active;
                r_rsp.error   <= dur_zero;
            end else begin
                // final step returns the remaining distance
                r_rsp.step    <= (r_active && ended) ? (r_goal - r_pos) : '0;
                r_rsp.running <= 1'b0;
                r_rsp.error   <= 1'b0;
            end
        end else if ((r_state == ST_DIV) && unit_sts.done) begin
            r_rsp.step    <= '0;
            r_rsp.running <= 1'b1;
            r_rsp.error   <= 1'b0;
        end else if ((r_state == ST_MUL) && unit_sts.done) begin
            r_rsp.step    <= mstep;
            r_rsp.running <= 1'b1;
            r_rsp.error   <= 1'b0;
        end
    end

    assign o_out_rsp = r_rsp;

endmodule

>>> src/tlr_checker.sv
// ----------------------------------------------------------------------------
// tlr_checker
// Port-level checks for the timed linear ramp, bound to the top level.
// ----------------------------------------------------------------------------
module tlr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input tlr_pkg::t_in_req  i_in_req,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input tlr_pkg::t_out_rsp o_out_rsp
);
    import tlr_pkg::*;

    // a pending response holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("response dropped or changed while stalled");

    // one request in flight: no intake while a response is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while response pending");

    // intake closes right after a request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

    // a rejected start carries no step
    a_error_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.error |-> o_out_rsp.step == '0)
        else $error("error response with nonzero step");

    // a start with zero duration reports an error on the next cycle
    a_zero_dur_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_req.func == FUNC_START)
            && (i_in_req.duration_ms == '0)
        |=> o_out_valid && o_out_rsp.error)
        else $error("zero duration start not flagged");

endmodule

bind timed_linear_ramp tlr_checker u_tlr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);
